[rtl/psl_pkg.sv]
// Package for the Pascal subset lexer: transaction types, token kinds, scan modes,
// keyword table and the character class helpers used by the lexer core.
// No dependencies.
package psl_pkg;

    localparam int KEYWORD_COUNT = 8;
    localparam int KW_MAX_LEN    = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] text;
        logic       end_of_run;
    } t_out;

    // Token kinds
    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_ID      = 5'd1;
    localparam logic [4:0] K_INT     = 5'd2;
    localparam logic [4:0] K_REALC   = 5'd3;
    localparam logic [4:0] K_KW0     = 5'd4;
    localparam logic [4:0] K_ASSIGN  = 5'd12;
    localparam logic [4:0] K_COLON   = 5'd13;
    localparam logic [4:0] K_COMMA   = 5'd14;
    localparam logic [4:0] K_DOT     = 5'd15;
    localparam logic [4:0] K_SEMI    = 5'd16;
    localparam logic [4:0] K_LPAREN  = 5'd17;
    localparam logic [4:0] K_RPAREN  = 5'd18;
    localparam logic [4:0] K_PLUS    = 5'd19;
    localparam logic [4:0] K_MINUS   = 5'd20;
    localparam logic [4:0] K_STAR    = 5'd21;
    localparam logic [4:0] K_SLASH   = 5'd22;
    localparam logic [4:0] K_TEXT    = 5'd23;
    localparam logic [4:0] K_UNKNOWN = 5'd24;

    // Scan modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_IDENT   = 3'd1;
    localparam logic [2:0] M_INT     = 3'd2;
    localparam logic [2:0] M_REAL    = 3'd3;
    localparam logic [2:0] M_COLON   = 3'd4;
    localparam logic [2:0] M_COMMENT = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [3:0] LEN_SAT    = 4'd10;

    // Keywords padded to ten characters, first character in the top byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        "PROGRAM   ", "PROCEDURE ", "INTEGER   ", "BEGIN     ",
        "REAL      ", "DIV       ", "END       ", "VAR       "
    };
    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd7, 4'd9, 4'd7, 4'd5, 4'd4, 4'd3, 4'd3, 4'd3
    };

    // Outcome of a character seen with no token open
    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        logic [7:0] text;
        logic [2:0] mode;
        logic [7:0] alive;
        logic [3:0] len;
    } t_start;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_idchar(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    // Drop keywords that the next identifier character rules out
    function automatic logic [7:0] kw_filter(input logic [7:0] alive, input logic [3:0] len,
                                             input logic [7:0] c);
        logic [7:0] up;
        logic [7:0] res;
        up  = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
        res = alive;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (!((len < KW_LEN[i]) &&
                  (up == KW_TEXT[i][8*KW_MAX_LEN-1 - 8*len -: 8])))
                res[i] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [3:0] len_inc(input logic [3:0] len);
        return (len < LEN_SAT) ? len + 4'd1 : len;
    endfunction

    // Kind of a finished identifier: first live keyword of matching length
    function automatic logic [4:0] ident_kind(input logic [7:0] alive, input logic [3:0] len);
        logic [4:0] k;
        k = K_ID;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
            if (alive[i] && (KW_LEN[i] == len))
                k = K_KW0 + 5'(i);
        end
        return k;
    endfunction

    function automatic t_start start_char(input logic [7:0] c);
        t_start s;
        s.emit  = 1'b0;
        s.kind  = K_EOF;
        s.text  = 8'd0;
        s.mode  = M_IDLE;
        s.alive = '1;
        s.len   = 4'd0;
        if ((c == " ") || (c == CH_TAB) || (c == CH_NL)) begin
            s.emit = 1'b0;
        end else if (is_digit(c)) begin
            s.emit = 1'b1;
            s.kind = K_TEXT;
            s.text = c;
            s.mode = M_INT;
        end else if (is_alpha(c) || (c == "_")) begin
            s.emit  = 1'b1;
            s.kind  = K_TEXT;
            s.text  = c;
            s.mode  = M_IDENT;
            s.alive = kw_filter(8'hFF, 4'd0, c);
            s.len   = 4'd1;
        end else if (c == "{") begin
            s.mode = M_COMMENT;
        end else if (c == ":") begin
            s.mode = M_COLON;
        end else if (punct_kind(c) != K_EOF) begin
            s.emit = 1'b1;
            s.kind = punct_kind(c);
        end else begin
            s.emit = 1'b1;
            s.kind = K_UNKNOWN;
            s.text = c;
        end
        return s;
    endfunction

endpackage

[rtl/pascal_subset_lexer_core.sv]
// Pascal subset lexer top level: input register, one-pass token logic, result queue.
// Depends on psl_pkg for transaction types, token kinds, modes and keyword helpers.
//
// Streaming lexer for a small Pascal subset. One source byte enters per input
// transaction, with last marking the final byte of the source. Each byte yields
// zero to four result transactions: the characters of identifiers and numbers
// stream out as text-char results, the token kind follows on the first byte
// that ends the token, and last closes any open token and adds eof. The final
// result of each byte carries end_of_run. Whitespace and brace comments yield
// nothing. Throughput: one input byte per cycle while each byte yields at most one
// result and i_ready is high; a byte with several results holds the next byte until
// its last result leaves the four-entry result queue, which delivers one result per
// cycle while i_ready is high. Bytes with no result pass through without waiting
// for the queue. Lexer state (mode, live keyword mask, identifier length) is updated
// once per processed byte.
module pascal_subset_lexer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  psl_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output psl_pkg::t_out  o_data
);

    // Input register
    logic          r_in_valid;
    psl_pkg::t_in  r_in;

    // Lexer state
    logic [2:0]    r_mode,  n_mode;
    logic [7:0]    r_alive, n_alive;
    logic [3:0]    r_len,   n_len;

    // Result queue, head at entry zero
    psl_pkg::t_out r_buf [4];
    logic [2:0]    r_cnt;

    psl_pkg::t_out v_list [4];
    logic [2:0]    v_n;
    psl_pkg::t_start v_s;
    logic [7:0]    c;

    logic w_pop, w_proc, w_load;

    assign c = r_in.ch;

    // Token logic for the registered byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            v_list[k] = '0;
        end
        v_n     = 3'd0;
        n_mode  = r_mode;
        n_alive = r_alive;
        n_len   = r_len;
        v_s     = psl_pkg::start_char(c);

        unique case (r_mode)
            psl_pkg::M_IDENT: begin
                if (psl_pkg::is_idchar(c)) begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_TEXT, c, 1'b0};
                    v_n = v_n + 3'd1;
                    n_alive = psl_pkg::kw_filter(r_alive, r_len, c);
                    n_len   = psl_pkg::len_inc(r_len);
                end else begin
                    v_list[v_n[1:0]] = '{psl_pkg::ident_kind(r_alive, r_len), 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                    if (v_s.emit) begin
                        v_list[v_n[1:0]] = '{v_s.kind, v_s.text, 1'b0};
                        v_n = v_n + 3'd1;
                    end
                    n_mode  = v_s.mode;
                    n_alive = v_s.alive;
                    n_len   = v_s.len;
                end
            end
            psl_pkg::M_INT: begin
                if (psl_pkg::is_digit(c) || (c == ".")) begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_TEXT, c, 1'b0};
                    v_n = v_n + 3'd1;
                    if (c == ".") n_mode = psl_pkg::M_REAL;
                end else begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_INT, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                    if (v_s.emit) begin
                        v_list[v_n[1:0]] = '{v_s.kind, v_s.text, 1'b0};
                        v_n = v_n + 3'd1;
                    end
                    n_mode  = v_s.mode;
                    n_alive = v_s.alive;
                    n_len   = v_s.len;
                end
            end
            psl_pkg::M_REAL: begin
                if (psl_pkg::is_digit(c)) begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_TEXT, c, 1'b0};
                    v_n = v_n + 3'd1;
                end else begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_REALC, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                    if (v_s.emit) begin
                        v_list[v_n[1:0]] = '{v_s.kind, v_s.text, 1'b0};
                        v_n = v_n + 3'd1;
                    end
                    n_mode  = v_s.mode;
                    n_alive = v_s.alive;
                    n_len   = v_s.len;
                end
            end
            psl_pkg::M_COLON: begin
                if (c == "=") begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_ASSIGN, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                    n_mode = psl_pkg::M_IDLE;
                end else begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_COLON, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                    if (v_s.emit) begin
                        v_list[v_n[1:0]] = '{v_s.kind, v_s.text, 1'b0};
                        v_n = v_n + 3'd1;
                    end
                    n_mode  = v_s.mode;
                    n_alive = v_s.alive;
                    n_len   = v_s.len;
                end
            end
            psl_pkg::M_COMMENT: begin
                if (c == "}") n_mode = psl_pkg::M_IDLE;
            end
            default: begin
                if (v_s.emit) begin
                    v_list[v_n[1:0]] = '{v_s.kind, v_s.text, 1'b0};
                    v_n = v_n + 3'd1;
                end
                n_mode  = v_s.mode;
                n_alive = v_s.alive;
                n_len   = v_s.len;
            end
        endcase

        // End of source: close the open token, add eof, return to reset state
        if (r_in.last) begin
            unique case (n_mode)
                psl_pkg::M_IDENT: begin
                    v_list[v_n[1:0]] = '{psl_pkg::ident_kind(n_alive, n_len), 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                end
                psl_pkg::M_INT: begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_INT, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                end
                psl_pkg::M_REAL: begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_REALC, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                end
                psl_pkg::M_COLON: begin
                    v_list[v_n[1:0]] = '{psl_pkg::K_COLON, 8'd0, 1'b0};
                    v_n = v_n + 3'd1;
                end
                default: begin
                end
            endcase
            v_list[v_n[1:0]] = '{psl_pkg::K_EOF, 8'd0, 1'b0};
            v_n = v_n + 3'd1;
            n_mode  = psl_pkg::M_IDLE;
            n_alive = '1;
            n_len   = 4'd0;
        end

        // Tag the last result of this byte
        if (v_n != 3'd0) begin
            v_list[v_n[1:0] - 2'd1].end_of_run = 1'b1;
        end
    end

    // Handshake: process when the byte makes no result or the queue drains this cycle
    assign w_pop   = o_valid && i_ready;
    assign w_proc  = r_in_valid &&
                     ((v_n == 3'd0) || (r_cnt == 3'd0) || ((r_cnt == 3'd1) && w_pop));
    assign w_load  = w_proc && (v_n != 3'd0);
    assign o_ready = !r_in_valid || w_proc;
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_buf[0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= psl_pkg::M_IDLE;
            r_alive    <= '1;
            r_len      <= 4'd0;
            r_cnt      <= 3'd0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (w_proc) begin
                r_mode  <= n_mode;
                r_alive <= n_alive;
                r_len   <= n_len;
            end
            if (w_load)     r_cnt <= v_n;
            else if (w_pop) r_cnt <= r_cnt - 3'd1;
        end
    end

    // Payload registers: hold the byte, load or advance the result queue
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_data;
        if (w_load) begin
            for (int k = 0; k < 4; k++) begin
                r_buf[k] <= v_list[k];
            end
        end else if (w_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    // Queue never holds more than one byte's worth of results
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue count out of range");

    // Keyword mask and length stay at reset values outside an identifier
    a_ident_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != psl_pkg::M_IDENT) |-> ((r_alive == 8'hFF) && (r_len == 4'd0)))
        else $error("identifier state not cleared outside identifier");

    // End of source always yields eof and leaves the lexer idle
    a_last_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.last) |-> (v_n != 3'd0))
        else $error("end of source without eof");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.last) |=> (r_mode == psl_pkg::M_IDLE))
        else $error("lexer not idle after end of source");

    // Identifier length saturates
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= psl_pkg::LEN_SAT)
        else $error("identifier length beyond saturation");

endmodule
